@@ sv/ilp_pkg.sv @@
// Types, parse-phase codes and literal-kind codes shared by the literal parser files.
package ilp_pkg;

    localparam int unsigned PHASE_W = 5;

    localparam logic [PHASE_W-1:0] PH_START    = 5'd0;
    localparam logic [PHASE_W-1:0] PH_SIGN     = 5'd1;
    localparam logic [PHASE_W-1:0] PH_DEC      = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ZERO     = 5'd3;
    localparam logic [PHASE_W-1:0] PH_OCT      = 5'd4;
    localparam logic [PHASE_W-1:0] PH_HEXPFX   = 5'd5;
    localparam logic [PHASE_W-1:0] PH_HEX      = 5'd6;
    localparam logic [PHASE_W-1:0] PH_QOPEN    = 5'd7;
    localparam logic [PHASE_W-1:0] PH_ESC      = 5'd8;
    localparam logic [PHASE_W-1:0] PH_XFIRST   = 5'd9;
    localparam logic [PHASE_W-1:0] PH_XMORE    = 5'd10;
    localparam logic [PHASE_W-1:0] PH_UHEX     = 5'd11;
    localparam logic [PHASE_W-1:0] PH_OESC     = 5'd12;
    localparam logic [PHASE_W-1:0] PH_CONT     = 5'd13;
    localparam logic [PHASE_W-1:0] PH_AFTER_E0 = 5'd14;
    localparam logic [PHASE_W-1:0] PH_AFTER_ED = 5'd15;
    localparam logic [PHASE_W-1:0] PH_AFTER_F0 = 5'd16;
    localparam logic [PHASE_W-1:0] PH_AFTER_F4 = 5'd17;
    localparam logic [PHASE_W-1:0] PH_CLOSE    = 5'd18;
    localparam logic [PHASE_W-1:0] PH_DONE     = 5'd19;

    localparam logic [1:0] KIND_DEC  = 2'd0;
    localparam logic [1:0] KIND_OCT  = 2'd1;
    localparam logic [1:0] KIND_HEX  = 2'd2;
    localparam logic [1:0] KIND_CHAR = 2'd3;

    // Decimal overflow limits
    localparam logic [63:0] DEC_LIMIT = 64'h1999_9999_9999_9999;
    localparam logic [63:0] DEC_WRAP  = 64'h0CCC_CCCC_CCCC_CCCC;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic signed [63:0] value;
        logic [1:0]         literal_kind;
    } t_out_item;

    typedef struct packed {
        logic [PHASE_W-1:0] parse_phase;
        logic               negative_sign;
        logic [63:0]        accumulator;
        logic [3:0]         digit_count;
        logic [1:0]         utf8_bytes_left;
        logic               failed;
    } t_parse_state;

    // Result before the sign is applied
    typedef struct packed {
        logic        accepted;
        logic        negate;
        logic [63:0] magnitude;
        logic [1:0]  literal_kind;
    } t_step_result;

    localparam t_parse_state STATE_RESET = '{
        parse_phase:     PH_START,
        negative_sign:   1'b0,
        accumulator:     64'd0,
        digit_count:     4'd0,
        utf8_bytes_left: 2'd0,
        failed:          1'b0
    };

endpackage

@@ sv/int_literal_parser.sv @@
// Top level of the streaming integer / character literal parser.
//
//  channel | direction | payload     | transaction
//  --------+-----------+-------------+------------------------------------------
//  in      | input     | t_in_item   | one token byte, last_byte marks the end
//  out     | output    | t_out_item  | one verdict per token, after its last byte
//
//  One byte per cycle sustained unless a stalled output holds back a last byte; a
//  byte is registered, stepped through the parser state from the input register and
//  the verdict lands in the result register, from which the token's result is offered.
//  The sign is applied between the result register and the output port.
//  Reset returns the parser to the start of a token and empties both registers.
//  A stalled output holds back only a last byte; other bytes keep flowing.
module int_literal_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ilp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ilp_pkg::t_out_item o_out_data
);
    import ilp_pkg::*;

    logic         r_in_valid;
    t_in_item     r_in;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    t_step_result r_out;
    t_step_result n_out;
    logic         out_free;
    logic         step_fire;

    ilp_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    // only a last byte needs room in the result register
    assign step_fire  = r_in_valid && (!r_in.last_byte || out_free);
    assign o_in_ready = !r_in_valid || step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step_fire) begin
                r_state <= n_state;
            end
            if (step_fire && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (step_fire && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_data.accepted     = r_out.accepted;
    assign o_out_data.value        = r_out.negate ? (64'd0 - r_out.magnitude) : r_out.magnitude;
    assign o_out_data.literal_kind = r_out.literal_kind;

endmodule

@@ sv/ilp_step.sv @@
// Next-state and result logic for one byte of a literal token.
module ilp_step (
    input  ilp_pkg::t_parse_state i_state,
    input  ilp_pkg::t_in_item     i_item,
    output ilp_pkg::t_parse_state o_state,
    output ilp_pkg::t_step_result o_result
);
    import ilp_pkg::*;

    logic [7:0]   b;
    logic [63:0]  acc;
    logic         hex_ok;
    logic [3:0]   hex_val;
    logic         oct_digit;
    logic         dec_digit;
    logic [63:0]  dec_next;
    logic         dec_fail;
    logic         cont_in_range;
    logic [7:0]   cont_lo;
    logic [7:0]   cont_hi;
    logic [1:0]   ubl_dec;
    logic [3:0]   oesc_cnt;
    t_parse_state n;

    always_comb begin
        b   = i_item.text_byte;
        acc = i_state.accumulator;

        hex_ok  = 1'b1;
        hex_val = b[3:0];
        if (b >= "0" && b <= "9") begin
            hex_val = b[3:0];
        end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            hex_val = b[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end

        oct_digit = (b >= "0") && (b <= "7");
        dec_digit = (b >= "0") && (b <= "9");

        // acc * 10 + d as a shift-add; reject if it cannot fit in 2^64-1
        dec_next = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {60'd0, b[3:0]};
        dec_fail = (acc > DEC_LIMIT) || ((acc > DEC_WRAP) && !dec_next[63]);

        cont_lo = 8'h80;
        cont_hi = 8'hBF;
        case (i_state.parse_phase)
            PH_AFTER_E0: cont_lo = 8'hA0;
            PH_AFTER_ED: cont_hi = 8'h9F;
            PH_AFTER_F0: cont_lo = 8'h90;
            PH_AFTER_F4: cont_hi = 8'h8F;
            default: ;
        endcase
        cont_in_range = (b >= cont_lo) && (b <= cont_hi);
        ubl_dec  = i_state.utf8_bytes_left - 2'd1;
        oesc_cnt = i_state.digit_count + 4'd1;

        n = i_state;
        if (!i_state.failed) begin
            case (i_state.parse_phase)
                PH_START, PH_SIGN: begin
                    if (i_state.parse_phase == PH_START && b == "'") begin
                        n.parse_phase = PH_QOPEN;
                    end else if (i_state.parse_phase == PH_START && b == "-") begin
                        n.negative_sign = 1'b1;
                        n.parse_phase   = PH_SIGN;
                    end else if (i_state.parse_phase == PH_START && b == "+") begin
                        n.parse_phase = PH_SIGN;
                    end else if (b == "0") begin
                        n.parse_phase = PH_ZERO;
                    end else if (dec_digit) begin
                        if (dec_fail) begin
                            n.failed = 1'b1;
                        end else begin
                            n.accumulator = dec_next;
                            n.parse_phase = PH_DEC;
                        end
                    end else begin
                        n.failed = 1'b1;
                    end
                end
                PH_DEC: begin
                    if (dec_digit && !dec_fail) begin
                        n.accumulator = dec_next;
                    end else begin
                        n.failed = 1'b1;
                    end
                end
                PH_ZERO, PH_OCT: begin
                    if (i_state.parse_phase == PH_ZERO && b == "x") begin
                        n.parse_phase = PH_HEXPFX;
                    end else if (oct_digit && acc[63:61] == 3'd0) begin
                        n.accumulator = {acc[60:0], b[2:0]};
                        n.parse_phase = PH_OCT;
                    end else begin
                        n.failed = 1'b1;
                    end
                end
                PH_HEXPFX, PH_HEX: begin
                    if (hex_ok && acc[63:60] == 4'd0) begin
                        n.accumulator = {acc[59:0], hex_val};
                        n.parse_phase = PH_HEX;
                    end else begin
                        n.failed = 1'b1;
                    end
                end
                PH_QOPEN: begin
                    if (b == "\\") begin
                        n.parse_phase = PH_ESC;
                    end else if (b < 8'h80) begin
                        n.accumulator = {56'd0, b};
                        n.parse_phase = PH_CLOSE;
                    end else if (b >= 8'hC2 && b <= 8'hDF) begin
                        n.accumulator     = {59'd0, b[4:0]};
                        n.utf8_bytes_left = 2'd1;
                        n.parse_phase     = PH_CONT;
                    end else if (b >= 8'hE0 && b <= 8'hEF) begin
                        n.accumulator     = {60'd0, b[3:0]};
                        n.utf8_bytes_left = 2'd2;
                        if (b == 8'hE0) begin
                            n.parse_phase = PH_AFTER_E0;
                        end else if (b == 8'hED) begin
                            n.parse_phase = PH_AFTER_ED;
                        end else begin
                            n.parse_phase = PH_CONT;
                        end
                    end else if (b >= 8'hF0 && b <= 8'hF4) begin
                        n.accumulator     = {61'd0, b[2:0]};
                        n.utf8_bytes_left = 2'd3;
                        if (b == 8'hF0) begin
                            n.parse_phase = PH_AFTER_F0;
                        end else if (b == 8'hF4) begin
                            n.parse_phase = PH_AFTER_F4;
                        end else begin
                            n.parse_phase = PH_CONT;
                        end
                    end else begin
                        n.failed = 1'b1;
                    end
                end
                PH_ESC: begin
                    n.parse_phase = PH_CLOSE;
                    case (b)
                        "a":  n.accumulator = 64'd7;
                        "b":  n.accumulator = 64'd8;
                        "f":  n.accumulator = 64'd12;
                        "n":  n.accumulator = 64'd10;
                        "r":  n.accumulator = 64'd13;
                        "t":  n.accumulator = 64'd9;
                        "v":  n.accumulator = 64'd11;
                        "\\": n.accumulator = 64'd92;
                        "'":  n.accumulator = 64'd39;
                        "\"": n.accumulator = 64'd34;
                        "?":  n.accumulator = 64'd63;
                        "x":  n.parse_phase = PH_XFIRST;
                        "u": begin
                            n.digit_count = 4'd4;
                            n.parse_phase = PH_UHEX;
                        end
                        "U": begin
                            n.digit_count = 4'd8;
                            n.parse_phase = PH_UHEX;
                        end
                        default: begin
                            if (oct_digit) begin
                                n.accumulator = {61'd0, b[2:0]};
                                n.digit_count = 4'd1;
                                n.parse_phase = PH_OESC;
                            end else begin
                                n.parse_phase = i_state.parse_phase;
                                n.failed      = 1'b1;
                            end
                        end
                    endcase
                end
                PH_XFIRST, PH_XMORE: begin
                    if (hex_ok) begin
                        // keep the low 32 bits of the code point
                        n.accumulator = {32'd0, acc[27:0], hex_val};
                        n.parse_phase = PH_XMORE;
                    end else if (i_state.parse_phase == PH_XMORE && b == "'") begin
                        n.parse_phase = PH_DONE;
                    end else begin
                        n.failed = 1'b1;
                    end
                end
                PH_UHEX: begin
                    if (!hex_ok || i_state.digit_count == 4'd0) begin
                        n.failed = 1'b1;
                    end else begin
                        n.accumulator = {32'd0, acc[27:0], hex_val};
                        n.digit_count = i_state.digit_count - 4'd1;
                        if (i_state.digit_count == 4'd1) begin
                            n.parse_phase = PH_CLOSE;
                        end
                    end
                end
                PH_OESC: begin
                    if (oct_digit) begin
                        n.accumulator = {acc[60:0], b[2:0]};
                        n.digit_count = oesc_cnt;
                        if (oesc_cnt >= 4'd3) begin
                            n.parse_phase = PH_CLOSE;
                        end
                    end else if (b == "'") begin
                        n.parse_phase = PH_DONE;
                    end else begin
                        n.failed = 1'b1;
                    end
                end
                PH_CONT, PH_AFTER_E0, PH_AFTER_ED, PH_AFTER_F0, PH_AFTER_F4: begin
                    if (cont_in_range) begin
                        n.accumulator     = {acc[57:0], b[5:0]};
                        n.utf8_bytes_left = ubl_dec;
                        n.parse_phase     = (ubl_dec == 2'd0) ? PH_CLOSE : PH_CONT;
                    end else begin
                        n.failed = 1'b1;
                    end
                end
                PH_CLOSE: begin
                    if (b == "'") begin
                        n.parse_phase = PH_DONE;
                    end else begin
                        n.failed = 1'b1;
                    end
                end
                default: n.failed = 1'b1;
            endcase
        end

        o_result = '{accepted: 1'b0, negate: 1'b0, magnitude: 64'd0, literal_kind: KIND_DEC};
        if (!n.failed) begin
            case (n.parse_phase)
                PH_DEC: o_result = '{accepted: 1'b1, negate: n.negative_sign,
                                     magnitude: n.accumulator, literal_kind: KIND_DEC};
                PH_ZERO, PH_OCT:
                    o_result = '{accepted: 1'b1, negate: n.negative_sign,
                                 magnitude: n.accumulator, literal_kind: KIND_OCT};
                PH_HEX: o_result = '{accepted: 1'b1, negate: n.negative_sign,
                                     magnitude: n.accumulator, literal_kind: KIND_HEX};
                PH_DONE: o_result = '{accepted: 1'b1, negate: 1'b0,
                                      magnitude: n.accumulator, literal_kind: KIND_CHAR};
                default: ;
            endcase
        end

        // the last byte closes the token: start afresh
        o_state = i_item.last_byte ? STATE_RESET : n;
    end

endmodule

@@ sv/ilp_checker.sv @@
// Port-level checks for the literal parser, bound to the top level.
module ilp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ilp_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ilp_pkg::t_out_item o_out_data
);
    import ilp_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.accepted |->
            o_out_data.value == 64'sd0 && o_out_data.literal_kind == KIND_DEC)
        else $error("rejected token carries a value or kind");

    a_char_32bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted && o_out_data.literal_kind == KIND_CHAR |->
            o_out_data.value[63:32] == 32'd0)
        else $error("character code point wider than 32 bits");

    // with the result register empty, nothing may block the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no result pending");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending straight after reset");

endmodule

bind int_literal_parser ilp_checker u_ilp_checker (.*);

@@ test/tb_int_literal_parser.sv @@
// Self-checking testbench for the streaming literal parser: directed and random tokens.
module tb_int_literal_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import ilp_pkg::*;

    typedef enum logic [1:0] {PACE_BURST, PACE_SPREAD, PACE_SPARSE} t_pace;

    localparam int unsigned CYCLE_LIMIT = 400_000;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;

    t_in_item     pending_bytes[$];
    logic [7:0]   token_buf[$];
    t_out_item    verdict_q[$];
    t_parse_state lit_state = STATE_RESET;

    string hex_chars = "0123456789abcdefABCDEF";
    string esc_chars = "abfnrtv\\'\"?";

    t_pace       in_pace     = PACE_SPARSE;
    t_pace       out_pace    = PACE_SPARSE;
    int          gap_left    = 0;
    int          stall_left  = 0;
    int unsigned total_bytes = 0;
    int unsigned bytes_taken = 0;
    int unsigned result_count = 0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    int_literal_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait(t_pace pace);
        case (pace)
            PACE_BURST:  return 0;
            PACE_SPREAD: return $urandom_range(0, 18);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        endcase
    endfunction

    function automatic int hex_value(logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    // Accept a decimal digit only if the value still fits in 64 bits unsigned
    function automatic void add_decimal(logic [3:0] d);
        logic        wraps;
        logic [63:0] next_acc;
        if (lit_state.accumulator > DEC_LIMIT) begin
            lit_state.failed = 1'b1;
        end else begin
            wraps    = lit_state.accumulator > DEC_WRAP;
            next_acc = lit_state.accumulator * 64'd10 + 64'(d);
            if (wraps && !next_acc[63]) begin
                lit_state.failed = 1'b1;
            end else begin
                lit_state.accumulator = next_acc;
                lit_state.parse_phase = PH_DEC;
            end
        end
    endfunction

    function automatic void add_continuation(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
        if (b < lo || b > hi) begin
            lit_state.failed = 1'b1;
        end else begin
            lit_state.accumulator     = {lit_state.accumulator[57:0], b[5:0]};
            lit_state.utf8_bytes_left = lit_state.utf8_bytes_left - 2'd1;
            lit_state.parse_phase     = (lit_state.utf8_bytes_left == 2'd0) ? PH_CLOSE : PH_CONT;
        end
    endfunction

    // Advance the parser by one byte; return 1 with the verdict on the last byte of a token
    function automatic bit parse_byte(t_in_item item, output t_out_item verdict);
        logic [7:0]  b;
        int          h;
        logic [63:0] signed_val;
        b = item.text_byte;
        h = hex_value(b);
        verdict = '0;
        if (!lit_state.failed) begin
            case (lit_state.parse_phase)
                PH_START, PH_SIGN: begin
                    if (lit_state.parse_phase == PH_START && b == "'") begin
                        lit_state.parse_phase = PH_QOPEN;
                    end else if (lit_state.parse_phase == PH_START && (b == "-" || b == "+")) begin
                        lit_state.negative_sign = (b == "-");
                        lit_state.parse_phase   = PH_SIGN;
                    end else if (b == "0") begin
                        lit_state.parse_phase = PH_ZERO;
                    end else if (b >= "1" && b <= "9") begin
                        add_decimal(4'(b - "0"));
                    end else begin
                        lit_state.failed = 1'b1;
                    end
                end
                PH_DEC: begin
                    if (b >= "0" && b <= "9") add_decimal(4'(b - "0"));
                    else lit_state.failed = 1'b1;
                end
                PH_ZERO, PH_OCT: begin
                    if (lit_state.parse_phase == PH_ZERO && b == "x") begin
                        lit_state.parse_phase = PH_HEXPFX;
                    end else if (b < "0" || b > "7" || lit_state.accumulator[63:61] != 3'd0) begin
                        lit_state.failed = 1'b1;
                    end else begin
                        lit_state.accumulator = {lit_state.accumulator[60:0], 3'(b - "0")};
                        lit_state.parse_phase = PH_OCT;
                    end
                end
                PH_HEXPFX, PH_HEX: begin
                    if (h < 0 || lit_state.accumulator[63:60] != 4'd0) begin
                        lit_state.failed = 1'b1;
                    end else begin
                        lit_state.accumulator = {lit_state.accumulator[59:0], 4'(h)};
                        lit_state.parse_phase = PH_HEX;
                    end
                end
                PH_QOPEN: begin
                    if (b == "\\") begin
                        lit_state.parse_phase = PH_ESC;
                    end else if (b < 8'h80) begin
                        lit_state.accumulator = 64'(b);
                        lit_state.parse_phase = PH_CLOSE;
                    end else if (b >= 8'hC2 && b <= 8'hDF) begin
                        lit_state.accumulator     = 64'(b[4:0]);
                        lit_state.utf8_bytes_left = 2'd1;
                        lit_state.parse_phase     = PH_CONT;
                    end else if (b >= 8'hE0 && b <= 8'hEF) begin
                        lit_state.accumulator     = 64'(b[3:0]);
                        lit_state.utf8_bytes_left = 2'd2;
                        lit_state.parse_phase     = (b == 8'hE0) ? PH_AFTER_E0 :
                                                    (b == 8'hED) ? PH_AFTER_ED : PH_CONT;
                    end else if (b >= 8'hF0 && b <= 8'hF4) begin
                        lit_state.accumulator     = 64'(b[2:0]);
                        lit_state.utf8_bytes_left = 2'd3;
                        lit_state.parse_phase     = (b == 8'hF0) ? PH_AFTER_F0 :
                                                    (b == 8'hF4) ? PH_AFTER_F4 : PH_CONT;
                    end else begin
                        lit_state.failed = 1'b1;
                    end
                end
                PH_ESC: begin
                    lit_state.parse_phase = PH_CLOSE;
                    case (b)
                        "a": lit_state.accumulator = 64'd7;
                        "b": lit_state.accumulator = 64'd8;
                        "f": lit_state.accumulator = 64'd12;
                        "n": lit_state.accumulator = 64'd10;
                        "r": lit_state.accumulator = 64'd13;
                        "t": lit_state.accumulator = 64'd9;
                        "v": lit_state.accumulator = 64'd11;
                        // these four stand for themselves
                        "\\", "'", "\"", "?": lit_state.accumulator = 64'(b);
                        "x": lit_state.parse_phase = PH_XFIRST;
                        "u": begin
                            lit_state.digit_count = 4'd4;
                            lit_state.parse_phase = PH_UHEX;
                        end
                        "U": begin
                            lit_state.digit_count = 4'd8;
                            lit_state.parse_phase = PH_UHEX;
                        end
                        default: begin
                            if (b >= "0" && b <= "7") begin
                                lit_state.accumulator = 64'(b - "0");
                                lit_state.digit_count = 4'd1;
                                lit_state.parse_phase = PH_OESC;
                            end else begin
                                lit_state.failed      = 1'b1;
                                lit_state.parse_phase = PH_ESC;
                            end
                        end
                    endcase
                end
                PH_XFIRST, PH_XMORE: begin
                    if (h >= 0) begin
                        lit_state.accumulator = {32'd0, lit_state.accumulator[27:0], 4'(h)};
                        lit_state.parse_phase = PH_XMORE;
                    end else if (lit_state.parse_phase == PH_XMORE && b == "'") begin
                        lit_state.parse_phase = PH_DONE;
                    end else begin
                        lit_state.failed = 1'b1;
                    end
                end
                PH_UHEX: begin
                    if (h < 0 || lit_state.digit_count == 4'd0) begin
                        lit_state.failed = 1'b1;
                    end else begin
                        lit_state.accumulator = {32'd0, lit_state.accumulator[27:0], 4'(h)};
                        lit_state.digit_count = lit_state.digit_count - 4'd1;
                        if (lit_state.digit_count == 4'd0) lit_state.parse_phase = PH_CLOSE;
                    end
                end
                PH_OESC: begin
                    if (b >= "0" && b <= "7") begin
                        lit_state.accumulator = {lit_state.accumulator[60:0], 3'(b - "0")};
                        lit_state.digit_count = lit_state.digit_count + 4'd1;
                        if (lit_state.digit_count >= 4'd3) lit_state.parse_phase = PH_CLOSE;
                    end else if (b == "'") begin
                        lit_state.parse_phase = PH_DONE;
                    end else begin
                        lit_state.failed = 1'b1;
                    end
                end
                PH_CONT:     add_continuation(b, 8'h80, 8'hBF);
                PH_AFTER_E0: add_continuation(b, 8'hA0, 8'hBF);
                PH_AFTER_ED: add_continuation(b, 8'h80, 8'h9F);
                PH_AFTER_F0: add_continuation(b, 8'h90, 8'hBF);
                PH_AFTER_F4: add_continuation(b, 8'h80, 8'h8F);
                PH_CLOSE: begin
                    if (b == "'") lit_state.parse_phase = PH_DONE;
                    else lit_state.failed = 1'b1;
                end
                default: lit_state.failed = 1'b1;
            endcase
        end
        if (!item.last_byte) return 1'b0;

        if (!lit_state.failed) begin
            signed_val = lit_state.negative_sign ? 64'd0 - lit_state.accumulator
                                                 : lit_state.accumulator;
            case (lit_state.parse_phase)
                PH_DEC: begin
                    verdict.accepted     = 1'b1;
                    verdict.value        = signed_val;
                    verdict.literal_kind = KIND_DEC;
                end
                PH_ZERO, PH_OCT: begin
                    verdict.accepted     = 1'b1;
                    verdict.value        = signed_val;
                    verdict.literal_kind = KIND_OCT;
                end
                PH_HEX: begin
                    verdict.accepted     = 1'b1;
                    verdict.value        = signed_val;
                    verdict.literal_kind = KIND_HEX;
                end
                PH_DONE: begin
                    verdict.accepted     = 1'b1;
                    verdict.value        = lit_state.accumulator;
                    verdict.literal_kind = KIND_CHAR;
                end
                default: ;
            endcase
        end
        lit_state = STATE_RESET;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        fail_count++;
        $display("mismatch in %s, verdict %0d: got %h, expected %h",
                 what, result_count, got, want);
    endtask

    task automatic append_text(string s);
        for (int k = 0; k < s.len(); k++) token_buf.push_back(s[k]);
    endtask

    task automatic queue_token();
        foreach (token_buf[k])
            pending_bytes.push_back(t_in_item'{text_byte: token_buf[k],
                                               last_byte: k == token_buf.size() - 1});
        token_buf.delete();
    endtask

    task automatic push_hex_digits(int count);
        repeat (count) token_buf.push_back(hex_chars[$urandom_range(0, 21)]);
    endtask

    // Mostly well-formed tokens with random content, some noise and damaged tokens
    task automatic build_random_token();
        int         shape;
        int         n;
        bit         all_sevens;
        logic [7:0] lead;
        shape = $urandom_range(0, 8);
        if (shape <= 3 && $urandom_range(0, 2) == 0)
            token_buf.push_back($urandom_range(0, 1) ? "-" : "+");
        case (shape)
            0, 1: begin
                if ($urandom_range(0, 3) == 0) begin
                    // last digit decides whether 2^64-1 is exceeded
                    append_text("1844674407370955161");
                    token_buf.push_back(8'("0" + $urandom_range(0, 9)));
                end else begin
                    token_buf.push_back(8'("0" + $urandom_range(1, 9)));
                    repeat ($urandom_range(0, 20))
                        token_buf.push_back(8'("0" + $urandom_range(0, 9)));
                end
            end
            2: begin
                token_buf.push_back("0");
                all_sevens = $urandom_range(0, 1);
                repeat ($urandom_range(0, 23)) begin
                    if (all_sevens) token_buf.push_back("7");
                    else token_buf.push_back(8'("0" + $urandom_range(0,
                                             ($urandom_range(0, 9) == 0) ? 9 : 7)));
                end
            end
            3: begin
                append_text("0x");
                push_hex_digits($urandom_range(0, 17));
            end
            4, 5, 6, 7: begin
                token_buf.push_back("'");
                case ($urandom_range(0, 5))
                    0: token_buf.push_back(8'($urandom_range(0, 127)));
                    1: begin
                        n = $urandom_range(1, 3);
                        if (n == 1) lead = 8'($urandom_range(8'hC0, 8'hDF));
                        else if (n == 2) lead = 8'($urandom_range(8'hE0, 8'hEF));
                        else lead = 8'($urandom_range(8'hF0, 8'hF7));
                        token_buf.push_back(lead);
                        if ($urandom_range(0, 7) == 0) n--;
                        repeat (n) begin
                            if ($urandom_range(0, 7) == 0) token_buf.push_back(8'($urandom));
                            else token_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                    end
                    2: begin
                        token_buf.push_back("\\");
                        if ($urandom_range(0, 7) == 0) token_buf.push_back(8'($urandom));
                        else token_buf.push_back(esc_chars[$urandom_range(0, 10)]);
                    end
                    3: begin
                        token_buf.push_back("\\");
                        repeat ($urandom_range(1, 4))
                            token_buf.push_back(8'("0" + $urandom_range(0, 7)));
                    end
                    4: begin
                        append_text("\\x");
                        push_hex_digits($urandom_range(0, 10));
                    end
                    default: begin
                        if ($urandom_range(0, 1)) begin
                            append_text("\\u");
                            n = 4;
                        end else begin
                            append_text("\\U");
                            n = 8;
                        end
                        if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 1) ? n + 1 : n - 1;
                        push_hex_digits(n);
                    end
                endcase
                token_buf.push_back("'");
            end
            default: repeat ($urandom_range(1, 6)) token_buf.push_back(8'($urandom));
        endcase

        case ($urandom_range(0, 11))
            0: token_buf[$urandom_range(0, token_buf.size() - 1)] = 8'($urandom);
            1: token_buf.push_back(8'($urandom));
            2: if (token_buf.size() > 1) void'(token_buf.pop_back());
            default: ;
        endcase
        queue_token();
    endtask

    // Sender: predict on every accepted byte, then present the next one after its gap
    always @(posedge i_clk) begin : in_side
        t_out_item verdict;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            gap_left   = 0;
            lit_state  = STATE_RESET;
        end else begin
            if (i_in_valid && o_in_ready) begin
                bytes_taken++;
                if (parse_byte(i_in_data, verdict)) verdict_q.push_back(verdict);
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    i_in_data  <= pending_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) in_pace = t_pace'($urandom_range(0, 2));
                    gap_left = draw_wait(in_pace);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each verdict against the oldest prediction, then stall at random
    always @(posedge i_clk) begin : out_side
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected verdict", o_out_data.value, 64'd0);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_out_data.accepted !== want.accepted)
                        report_mismatch("accepted", 64'(o_out_data.accepted), 64'(want.accepted));
                    if (o_out_data.value !== want.value)
                        report_mismatch("value", o_out_data.value, want.value);
                    if (o_out_data.literal_kind !== want.literal_kind)
                        report_mismatch("literal_kind", 64'(o_out_data.literal_kind),
                                        64'(want.literal_kind));
                end
                result_count++;
                if ($urandom_range(0, 19) == 0) out_pace = t_pace'($urandom_range(0, 2));
                stall_left = draw_wait(out_pace);
            end else if (o_out_valid && stall_left > 0) begin
                stall_left--;
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        string directed_tokens[] = '{
            "0", "7", "-0", "+42", "08", "12a",
            "18446744073709551615", "18446744073709551616", "-9223372036854775808",
            "01777777777777777777777", "02000000000000000000000",
            "0xFFFFFFFFFFFFFFFF", "-0x10000000000000000", "0xaBcD", "0X1", "0x", "-",
            "''", "'a'", "'''", "'a'b", "'\\n'", "'\\q'", "'\\x123456789'",
            "'\\u20AC'", "'\\U0001F600'", "'\\101'", "'\\1012'", "'\\7'",
            "'\303\251'", "'\342\202\254'", "'\360\237\230\200'",
            "'\300\200'", "'\355\240\200'", "'\364\220\200\200'", "'\200'", "'\303'"
        };
        foreach (directed_tokens[k]) begin
            append_text(directed_tokens[k]);
            queue_token();
        end
        while (pending_bytes.size() < 1800) build_random_token();
        total_bytes = pending_bytes.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < total_bytes || verdict_q.size() != 0) @(posedge i_clk);
        // hold on past the pipeline depth to catch stray verdicts
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/ilp_pkg.sv
sv/ilp_step.sv
sv/int_literal_parser.sv
sv/ilp_checker.sv
test/tb_int_literal_parser.sv
